/* hdl/grr_pkg.sv */
`default_nettype none
package grr_pkg;

	// register map
	localparam int          NUM_REGS       = 5;
	localparam int          APB_ADDR_W     = 5;
	localparam int          APB_DATA_W     = 32;
	localparam logic [2:0]  REG_FG_COLOR   = 3'd0;
	localparam logic [2:0]  REG_BG_COLOR   = 3'd1;
	localparam logic [2:0]  REG_SCALE      = 3'd2;
	localparam logic [2:0]  REG_SCR_WIDTH  = 3'd3;
	localparam logic [2:0]  REG_SCR_HEIGHT = 3'd4;

	// register reset values
	localparam logic [15:0] FG_COLOR_RST   = 16'hFFFF;
	localparam logic [15:0] BG_COLOR_RST   = 16'h0000;
	localparam logic [7:0]  SCALE_RST      = 8'd1;
	localparam logic [10:0] SCR_WIDTH_RST  = 11'd320;
	localparam logic [10:0] SCR_HEIGHT_RST = 11'd240;

	// default clipping limit
	localparam int          MAX_SCREEN_DIM_DEF = 1024;

	// font geometry
	localparam int          GLYPH_COLS   = 5;
	localparam int          GLYPH_ROWS   = 7;
	localparam int          GLYPH_BITS   = GLYPH_COLS * GLYPH_ROWS;
	localparam int          GLYPH_COUNT  = 59;
	localparam logic [3:0]  CELL_W_MUL   = 4'd6;
	localparam logic [3:0]  CELL_H_MUL   = 4'd7;

	// character classes
	localparam logic [7:0]  CHAR_FIRST   = 8'd32;
	localparam logic [7:0]  CHAR_LAST    = 8'd90;
	localparam logic [7:0]  CHAR_SUB     = 8'h3F;
	localparam logic [7:0]  LOWER_FIRST  = 8'h61;
	localparam logic [7:0]  LOWER_LAST   = 8'h7A;
	localparam logic [7:0]  CASE_OFFSET  = 8'd32;

	// command queue between front and back
	localparam int          QUEUE_DEPTH  = 2;

	typedef struct packed {
		logic [15:0] fg_color;
		logic [15:0] bg_color;
		logic [7:0]  glyph_scale;
		logic [10:0] screen_width;
		logic [10:0] screen_height;
	} cfg_t;

	typedef struct packed {
		logic [15:0]           x;
		logic [15:0]           y;
		logic [GLYPH_BITS-1:0] glyph;
	} cmd_t;

	typedef struct packed {
		logic [9:0]  x;
		logic [9:0]  y;
		logic [10:0] w;
		logic [10:0] h;
		logic [15:0] color;
	} rect_t;

	// column bytes, rightmost column in the top byte, bit 0 = top row
	localparam logic [39:0] GLYPH_ROM [0:GLYPH_COUNT-1] = '{
		40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00,
		40'h14_7F_14_7F_14, 40'h12_2A_7F_2A_24, 40'h62_64_08_13_23,
		40'h50_22_55_49_36, 40'h00_00_03_05_00, 40'h00_41_22_1C_00,
		40'h00_1C_22_41_00, 40'h08_2A_1C_2A_08, 40'h08_08_3E_08_08,
		40'h00_00_30_50_00, 40'h08_08_08_08_08, 40'h00_00_60_60_00,
		40'h02_04_08_10_20, 40'h3E_45_49_51_3E, 40'h00_40_7F_42_00,
		40'h46_49_51_61_42, 40'h31_4B_45_41_21, 40'h10_7F_12_14_18,
		40'h39_45_45_45_27, 40'h30_49_49_4A_3C, 40'h03_05_09_71_01,
		40'h36_49_49_49_36, 40'h1E_29_49_49_06, 40'h00_00_36_36_00,
		40'h00_00_36_56_00, 40'h00_41_22_14_08, 40'h14_14_14_14_14,
		40'h08_14_22_41_00, 40'h06_09_51_01_02, 40'h3E_41_79_49_32,
		40'h7E_11_11_11_7E, 40'h36_49_49_49_7F, 40'h22_41_41_41_3E,
		40'h1C_22_41_41_7F, 40'h41_49_49_49_7F, 40'h01_09_09_09_7F,
		40'h7A_49_49_41_3E, 40'h7F_08_08_08_7F, 40'h00_41_7F_41_00,
		40'h01_3F_41_40_20, 40'h41_22_14_08_7F, 40'h40_40_40_40_7F,
		40'h7F_02_0C_02_7F, 40'h7F_10_08_04_7F, 40'h3E_41_41_41_3E,
		40'h06_09_09_09_7F, 40'h5E_21_51_41_3E, 40'h46_29_19_09_7F,
		40'h31_49_49_49_46, 40'h01_01_7F_01_01, 40'h3F_40_40_40_3F,
		40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F, 40'h63_14_08_14_63,
		40'h07_08_70_08_07, 40'h43_45_49_51_61
	};

	// glyph cells packed column-major, bit 0 = column 0 row 0
	function automatic logic [GLYPH_BITS-1:0] glyph_bits(input logic [5:0] idx);
		logic [39:0] e;
		e = (idx < 6'(GLYPH_COUNT)) ? GLYPH_ROM[idx] : 40'h0;
		return {e[38:32], e[30:24], e[22:16], e[14:8], e[6:0]};
	endfunction

endpackage
`default_nettype wire

/* hdl/grr_ifs.sv */
`default_nettype none
// character channel
interface grr_in_if;
	logic        valid;
	logic        ready;
	logic [7:0]  char_code;
	logic        new_string;
	logic [15:0] start_x;
	logic [15:0] start_y;

	modport source (output valid, char_code, new_string, start_x, start_y, input ready);
	modport sink (input valid, char_code, new_string, start_x, start_y, output ready);
endinterface

// rectangle command channel
interface grr_out_if;
	logic        valid;
	logic        ready;
	logic [9:0]  rect_x;
	logic [9:0]  rect_y;
	logic [10:0] rect_width;
	logic [10:0] rect_height;
	logic [15:0] rect_color;
	logic        is_last;

	modport source (output valid, rect_x, rect_y, rect_width, rect_height, rect_color,
		is_last, input ready);
	modport sink (input valid, rect_x, rect_y, rect_width, rect_height, rect_color,
		is_last, output ready);
endinterface
`default_nettype wire

/* hdl/grr_regs.sv */
`default_nettype none
module grr_regs (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [grr_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [grr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [grr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	output grr_pkg::cfg_t                        cfg
);
	import grr_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign pready  = 1'b1;
	assign reg_idx = paddr[APB_ADDR_W-1:2];
	assign wr_en   = psel && penable && pwrite && pready;
	assign cfg     = cfg_q;

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.fg_color      <= FG_COLOR_RST;
			cfg_q.bg_color      <= BG_COLOR_RST;
			cfg_q.glyph_scale   <= SCALE_RST;
			cfg_q.screen_width  <= SCR_WIDTH_RST;
			cfg_q.screen_height <= SCR_HEIGHT_RST;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_FG_COLOR:   cfg_q.fg_color      <= pwdata[15:0];
				REG_BG_COLOR:   cfg_q.bg_color      <= pwdata[15:0];
				REG_SCALE:      cfg_q.glyph_scale   <= pwdata[7:0];
				REG_SCR_WIDTH:  cfg_q.screen_width  <= pwdata[10:0];
				REG_SCR_HEIGHT: cfg_q.screen_height <= pwdata[10:0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		unique case (reg_idx)
			REG_FG_COLOR:   prdata = APB_DATA_W'(cfg_q.fg_color);
			REG_BG_COLOR:   prdata = APB_DATA_W'(cfg_q.bg_color);
			REG_SCALE:      prdata = APB_DATA_W'(cfg_q.glyph_scale);
			REG_SCR_WIDTH:  prdata = APB_DATA_W'(cfg_q.screen_width);
			REG_SCR_HEIGHT: prdata = APB_DATA_W'(cfg_q.screen_height);
			default:        prdata = '0;
		endcase
	end

endmodule
`default_nettype wire

/* hdl/grr_front.sv */
`default_nettype none
module grr_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire grr_pkg::cfg_t  cfg,
	grr_in_if.sink              char_in,
	output grr_pkg::cmd_t       cmd,
	output logic                cmd_valid,
	input  wire logic           cmd_ready
);
	import grr_pkg::*;

	logic [15:0] cursor_x_q;
	logic [15:0] cursor_y_q;
	logic [15:0] pos_x;
	logic [15:0] pos_y;
	logic [7:0]  code;
	logic [10:0] advance;
	logic        take;

	assign take          = char_in.valid && cmd_ready;
	assign char_in.ready = cmd_ready;
	assign cmd_valid     = char_in.valid;

	// cursor source and case folding
	always_comb begin
		pos_x = char_in.new_string ? char_in.start_x : cursor_x_q;
		pos_y = char_in.new_string ? char_in.start_y : cursor_y_q;
		code  = char_in.char_code;
		if (code >= LOWER_FIRST && code <= LOWER_LAST) begin
			code = code - CASE_OFFSET;
		end
		if (code < CHAR_FIRST || code > CHAR_LAST) begin
			code = CHAR_SUB;
		end
		advance   = {3'b000, cfg.glyph_scale} * {7'b0, CELL_W_MUL};
		cmd.x     = pos_x;
		cmd.y     = pos_y;
		cmd.glyph = glyph_bits(6'(code - CHAR_FIRST));
	end

	// cursor moves one cell per transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= '0;
			cursor_y_q <= '0;
		end else if (take) begin
			cursor_x_q <= pos_x + {5'b0, advance};
			cursor_y_q <= pos_y;
		end
	end

endmodule
`default_nettype wire

/* hdl/grr_queue.sv */
`default_nettype none
module grr_queue (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire grr_pkg::cmd_t wr_data,
	input  wire logic          wr_valid,
	output logic               wr_ready,
	output grr_pkg::cmd_t      rd_data,
	output logic               rd_valid,
	input  wire logic          rd_ready
);
	import grr_pkg::*;

	localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	cmd_t             mem_q [0:QUEUE_DEPTH-1];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign wr_ready = count_q != CNT_W'(QUEUE_DEPTH);
	assign rd_valid = count_q != '0;
	assign push     = wr_valid && wr_ready;
	assign pop      = rd_valid && rd_ready;
	assign rd_data  = mem_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= wr_data;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hdl/grr_back.sv */
`default_nettype none
module grr_back #(
	parameter int MAX_SCREEN_DIM = grr_pkg::MAX_SCREEN_DIM_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire grr_pkg::cfg_t cfg,
	input  wire grr_pkg::cmd_t cmd,
	input  wire logic          cmd_valid,
	output logic               cmd_ready,
	grr_out_if.source          rect_out
);
	import grr_pkg::*;

	// clip arithmetic width: 16-bit coordinate plus carry
	localparam int         CW       = 17;
	localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
	localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);
	localparam logic [CW-1:0] DIM_MAX = CW'(MAX_SCREEN_DIM);

	// scanner state
	logic                  busy_q;
	logic                  bg_q;
	logic [2:0]            col_q;
	logic [2:0]            row_q;
	logic [15:0]           base_x_q;
	logic [15:0]           base_y_q;
	logic [15:0]           cx_q;
	logic [15:0]           ry_q;
	logic [GLYPH_BITS-1:0] glyph_q;

	// one-deep hold so the last rectangle of a character can be marked
	logic                  pend_v_q;
	logic                  pend_done_q;
	rect_t                 pend_q;

	// output register
	logic                  out_v_q;
	logic                  out_last_q;
	rect_t                 out_q;

	logic [10:0]           cell_w;
	logic [10:0]           cell_h;
	logic [15:0]           cand_x;
	logic [15:0]           cand_y;
	logic [10:0]           cand_w;
	logic [10:0]           cand_h;
	logic [15:0]           cand_color;
	logic                  cand_bit;
	logic                  cand_v;
	rect_t                 cand;
	logic [CW-1:0]         sw_e;
	logic [CW-1:0]         sh_e;
	logic [CW-1:0]         xe;
	logic [CW-1:0]         ye;
	logic [CW-1:0]         x_end;
	logic [CW-1:0]         y_end;
	logic [CW-1:0]         w_clip;
	logic [CW-1:0]         h_clip;
	logic                  final_step;
	logic                  out_free;
	logic                  adv;
	logic                  push;
	logic                  load;

	// candidate rectangle for the current step
	always_comb begin
		cell_w     = {3'b000, cfg.glyph_scale} * {7'b0, CELL_W_MUL};
		cell_h     = {3'b000, cfg.glyph_scale} * {7'b0, CELL_H_MUL};
		cand_x     = bg_q ? base_x_q : cx_q;
		cand_y     = bg_q ? base_y_q : ry_q;
		cand_w     = bg_q ? cell_w : {3'b000, cfg.glyph_scale};
		cand_h     = bg_q ? cell_h : {3'b000, cfg.glyph_scale};
		cand_color = bg_q ? cfg.bg_color : cfg.fg_color;
		cand_bit   = bg_q || glyph_q[0];
		final_step = !bg_q && col_q == LAST_COL && row_q == LAST_ROW;
	end

	// clip against the screen
	always_comb begin
		sw_e   = (CW'(cfg.screen_width) > DIM_MAX) ? DIM_MAX : CW'(cfg.screen_width);
		sh_e   = (CW'(cfg.screen_height) > DIM_MAX) ? DIM_MAX : CW'(cfg.screen_height);
		xe     = CW'(cand_x);
		ye     = CW'(cand_y);
		x_end  = xe + CW'(cand_w);
		y_end  = ye + CW'(cand_h);
		w_clip = (x_end > sw_e) ? sw_e - xe : CW'(cand_w);
		h_clip = (y_end > sh_e) ? sh_e - ye : CW'(cand_h);
		cand_v = busy_q && cand_bit && cfg.glyph_scale != '0 && xe < sw_e && ye < sh_e;
		cand.x     = cand_x[9:0];
		cand.y     = cand_y[9:0];
		cand.w     = w_clip[10:0];
		cand.h     = h_clip[10:0];
		cand.color = cand_color;
	end

	// flow control
	assign out_free  = !out_v_q || rect_out.ready;
	assign adv       = busy_q && (out_free || !(pend_v_q && (pend_done_q || cand_v)));
	assign push      = out_free && pend_v_q && (pend_done_q || (busy_q && cand_v));
	assign load      = cmd_valid && (!busy_q || (adv && final_step));
	assign cmd_ready = load;

	// scanner control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			bg_q   <= 1'b0;
			col_q  <= '0;
			row_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			bg_q   <= 1'b1;
			col_q  <= '0;
			row_q  <= '0;
		end else if (adv) begin
			if (final_step) begin
				busy_q <= 1'b0;
			end else if (bg_q) begin
				bg_q <= 1'b0;
			end else if (row_q == LAST_ROW) begin
				row_q <= '0;
				col_q <= col_q + 1'b1;
			end else begin
				row_q <= row_q + 1'b1;
			end
		end
	end

	// scanner positions and glyph shift
	always_ff @(posedge clk) begin
		if (load) begin
			base_x_q <= cmd.x;
			base_y_q <= cmd.y;
			glyph_q  <= cmd.glyph;
		end else if (adv && !final_step) begin
			if (bg_q) begin
				cx_q <= base_x_q;
				ry_q <= base_y_q;
			end else begin
				glyph_q <= glyph_q >> 1;
				if (row_q == LAST_ROW) begin
					ry_q <= base_y_q;
					cx_q <= cx_q + {8'b0, cfg.glyph_scale};
				end else begin
					ry_q <= ry_q + {8'b0, cfg.glyph_scale};
				end
			end
		end
	end

	// hold register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q    <= 1'b0;
			pend_done_q <= 1'b0;
		end else begin
			if (adv && cand_v) begin
				pend_v_q    <= 1'b1;
				pend_done_q <= final_step;
			end else if (push) begin
				pend_v_q    <= 1'b0;
				pend_done_q <= 1'b0;
			end else if (adv && final_step && pend_v_q && !pend_done_q) begin
				pend_done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && cand_v) begin
			pend_q <= cand;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (push) begin
			out_v_q <= 1'b1;
		end else if (rect_out.ready) begin
			out_v_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			out_q      <= pend_q;
			out_last_q <= pend_done_q;
		end
	end

	assign rect_out.valid       = out_v_q;
	assign rect_out.rect_x      = out_q.x;
	assign rect_out.rect_y      = out_q.y;
	assign rect_out.rect_width  = out_q.w;
	assign rect_out.rect_height = out_q.h;
	assign rect_out.rect_color  = out_q.color;
	assign rect_out.is_last     = out_last_q;

`ifndef SYNTHESIS
	// a finished mark only sits on a held rectangle
	a_done_has_rect: assert property (@(posedge clk) disable iff (!arst_n)
		pend_done_q |-> pend_v_q)
		else $error("hold register marked last while empty");

	// a held rectangle is marked last once its character ends without a newer one
	a_mark_last: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && final_step && !cand_v && pend_v_q && !pend_done_q) |=> pend_done_q)
		else $error("last rectangle of a character not marked");

	// the glyph counters stay inside the cell grid
	a_grid: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (col_q <= LAST_COL && row_q <= LAST_ROW))
		else $error("glyph scan counter out of range");

	// an emitted rectangle is never empty
	a_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		out_v_q |-> (out_q.w != '0 && out_q.h != '0))
		else $error("empty rectangle emitted");
`endif

endmodule
`default_nettype wire

/* hdl/glyph_to_rect_renderer.sv */
`default_nettype none
// Character renderer for a 5x7 column font: each character transfer yields a
// background cell of 6*scale by 7*scale followed by one scale-sized square per
// lit font pixel, column by column, all clipped to the screen and tagged is_last
// on the final one. The front takes a character per cycle, while the two-entry
// command queue has room, and updates the cursor at once; the back scanner then
// takes one step for the background and one per font cell, with one rectangle
// leaving the output register per cycle at most, while the output is not stalled.
// Characters whose rectangles all fall off screen still take every scanner step.
// No clearing pass follows reset.
module glyph_to_rect_renderer #(
	parameter int MAX_SCREEN_DIM = grr_pkg::MAX_SCREEN_DIM_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            psel,
	input  wire logic                            penable,
	input  wire logic                            pwrite,
	input  wire logic [grr_pkg::APB_ADDR_W-1:0]  paddr,
	input  wire logic [grr_pkg::APB_DATA_W-1:0]  pwdata,
	output logic      [grr_pkg::APB_DATA_W-1:0]  prdata,
	output logic                                 pready,
	grr_in_if.sink                               char_in,
	grr_out_if.source                            rect_out
);
	import grr_pkg::*;

	cfg_t cfg;
	cmd_t front_cmd;
	cmd_t back_cmd;
	logic front_valid;
	logic front_ready;
	logic back_valid;
	logic back_ready;

	// configuration registers
	grr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// character intake and cursor
	grr_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.char_in   (char_in),
		.cmd       (front_cmd),
		.cmd_valid (front_valid),
		.cmd_ready (front_ready)
	);

	// command queue
	grr_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_data  (front_cmd),
		.wr_valid (front_valid),
		.wr_ready (front_ready),
		.rd_data  (back_cmd),
		.rd_valid (back_valid),
		.rd_ready (back_ready)
	);

	// rectangle scanner and clipper
	grr_back #(
		.MAX_SCREEN_DIM (MAX_SCREEN_DIM)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.cmd       (back_cmd),
		.cmd_valid (back_valid),
		.cmd_ready (back_ready),
		.rect_out  (rect_out)
	);

endmodule
`default_nettype wire
